// ----- rtl/assert_macros.svh -----
// Assertion macros used by the wtalu_chk checker module.
// Needs a clk and an active-low arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while in reset.
`define CHK_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("check failed");

// Clocked implication, off while in reset.
`define CHK_IMPLY(label, cond, prop) \
	`CHK_ASSERT(label, (cond) |-> (prop))

`endif

// ----- rtl/wtalu_pkg.sv -----
// Types, operation codes and helper functions of the width-tagged ALU.
// No dependencies.
package wtalu_pkg;

	localparam int DATA_BITS  = 64;
	localparam int WIDTH_BITS = 7;
	localparam int SHIFT_BITS = $clog2(DATA_BITS);
	localparam int HALF       = DATA_BITS / 2;

	typedef enum logic [4:0] {
		OP_NOT    = 5'd0,
		OP_AND    = 5'd1,
		OP_OR     = 5'd2,
		OP_XOR    = 5'd3,
		OP_BNOT   = 5'd4,
		OP_BAND   = 5'd5,
		OP_BOR    = 5'd6,
		OP_BXOR   = 5'd7,
		OP_SHL    = 5'd8,
		OP_SHR    = 5'd9,
		OP_WIDTH  = 5'd10,
		OP_SWIDTH = 5'd11,
		OP_ADD    = 5'd12,
		OP_SUB    = 5'd13,
		OP_MUL    = 5'd14,
		OP_DIV    = 5'd15,
		OP_SDIV   = 5'd16,
		OP_LT     = 5'd17,
		OP_GT     = 5'd18,
		OP_LE     = 5'd19,
		OP_GE     = 5'd20,
		OP_SLT    = 5'd21,
		OP_SGT    = 5'd22,
		OP_SLE    = 5'd23,
		OP_SGE    = 5'd24,
		OP_EQ     = 5'd25
	} op_t;

	typedef struct packed {
		logic [4:0]            action;
		logic [DATA_BITS-1:0]  lhs_value;
		logic [WIDTH_BITS-1:0] lhs_width;
		logic [DATA_BITS-1:0]  rhs_value;
		logic [WIDTH_BITS-1:0] rhs_width;
	} req_t;

	typedef struct packed {
		logic [DATA_BITS-1:0]  result_value;
		logic [WIDTH_BITS-1:0] result_width;
		logic                  divide_by_zero;
	} rsp_t;

	// Per-item control that travels down the pipeline.
	typedef struct packed {
		op_t                   op;
		logic [WIDTH_BITS-1:0] wid;
		logic                  dz;
		logic                  neg;
		logic [DATA_BITS-1:0]  val;
	} ctl_t;

	localparam logic [WIDTH_BITS-1:0] WMAX = WIDTH_BITS'(DATA_BITS);

	function automatic logic [WIDTH_BITS-1:0] sat_width(input logic [WIDTH_BITS-1:0] w);
		return (w > WMAX) ? WMAX : w;
	endfunction

	function automatic logic [DATA_BITS-1:0] width_mask(input logic [WIDTH_BITS-1:0] w);
		logic [DATA_BITS-1:0] m;
		if (w >= WMAX)
			m = '1;
		else
			m = (DATA_BITS'(1) << w) - DATA_BITS'(1);
		return m;
	endfunction

	function automatic logic [DATA_BITS-1:0] sign_ext(input logic [DATA_BITS-1:0] v,
	                                                  input logic [WIDTH_BITS-1:0] w);
		logic [DATA_BITS-1:0] m;
		logic [DATA_BITS-1:0] t;
		logic [DATA_BITS-1:0] r;
		m = width_mask(w);
		t = v >> (w - WIDTH_BITS'(1));
		if (w == '0)
			r = '0;
		else if (w >= WMAX)
			r = v;
		else
			r = (v & m) | (t[0] ? ~m : '0);
		return r;
	endfunction

endpackage

// ----- rtl/width_tagged_integer_alu.sv -----
// Top level of the width-tagged integer ALU.
// Depends on wtalu_pkg.
//
// One request enters per cycle and one response leaves per cycle while the pipe
// advances. Each request passes a decode stage, an operate stage, one radix-2
// restoring divider stage per quotient bit, and the output stage.
// The divider chain sets the latency; every operation travels through it so
// responses stay in request order. The whole pipe advances whenever the output
// register is empty or its response is being taken.
module width_tagged_integer_alu
	import wtalu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_rsp
);

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: decode, saturate widths, sign-extend
	logic                  valid_s1;
	op_t                   op_s1;
	logic [DATA_BITS-1:0]  a_s1, b_s1, sa_s1, sb_s1;
	logic [WIDTH_BITS-1:0] rw_s1;
	logic                  big_s1;

	logic [WIDTH_BITS-1:0] aw_c, bw_c, lw_c, rw_c, mx_c, mn_c;
	op_t                   op_c;

	always_comb begin
		op_c = op_t'(in_req.action);
		aw_c = sat_width(in_req.lhs_width);
		bw_c = sat_width(in_req.rhs_width);
		lw_c = (in_req.lhs_value > DATA_BITS'(DATA_BITS)) ? WMAX
			: in_req.lhs_value[WIDTH_BITS-1:0];
		mx_c = (aw_c > bw_c) ? aw_c : bw_c;
		mn_c = (aw_c < bw_c) ? aw_c : bw_c;
		case (op_c) inside
			OP_NOT, OP_AND, OP_OR, OP_XOR, OP_EQ,
			[OP_LT:OP_SGE]:                          rw_c = WIDTH_BITS'(1);
			OP_BNOT:                                 rw_c = bw_c;
			OP_BAND:                                 rw_c = mn_c;
			OP_BOR, OP_BXOR, OP_ADD, OP_SUB, OP_MUL: rw_c = mx_c;
			OP_SHL, OP_SHR, OP_DIV, OP_SDIV:         rw_c = aw_c;
			OP_WIDTH, OP_SWIDTH:                     rw_c = lw_c;
			default:                                 rw_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= op_c;
			a_s1   <= in_req.lhs_value;
			b_s1   <= in_req.rhs_value;
			rw_s1  <= rw_c;
			sa_s1  <= sign_ext(in_req.lhs_value, aw_c);
			sb_s1  <= sign_ext(in_req.rhs_value, bw_c);
			big_s1 <= in_req.rhs_value >= DATA_BITS'(DATA_BITS);
		end
	end

	// ---------------- stage 2: simple results, partial products, divide prep
	logic                  valid_s2;
	ctl_t                  ctl_s2;
	logic [DATA_BITS-1:0]  pll_s2, plh_s2, phl_s2, dvd_s2, dsr_s2;

	ctl_t                  ctl_c;
	logic [DATA_BITS-1:0]  dvd_c, dsr_c;
	logic                  sd_c, na_c, nb_c;

	always_comb begin
		sd_c = (op_s1 == OP_SDIV);
		na_c = sd_c && sa_s1[DATA_BITS-1];
		nb_c = sd_c && sb_s1[DATA_BITS-1];
		dvd_c = sd_c ? (na_c ? -sa_s1 : sa_s1) : a_s1;
		dsr_c = sd_c ? (nb_c ? -sb_s1 : sb_s1) : b_s1;
		ctl_c.op  = op_s1;
		ctl_c.wid = rw_s1;
		ctl_c.neg = na_c ^ nb_c;
		ctl_c.dz  = ((op_s1 == OP_DIV) && (b_s1 == '0))
			|| (sd_c && (sb_s1 == '0));
		case (op_s1)
			OP_NOT:    ctl_c.val = DATA_BITS'(b_s1 == '0);
			OP_AND:    ctl_c.val = DATA_BITS'((a_s1 != '0) && (b_s1 != '0));
			OP_OR:     ctl_c.val = DATA_BITS'((a_s1 != '0) || (b_s1 != '0));
			OP_XOR:    ctl_c.val = DATA_BITS'((a_s1 != '0) != (b_s1 != '0));
			OP_BNOT:   ctl_c.val = ~b_s1;
			OP_BAND:   ctl_c.val = a_s1 & b_s1;
			OP_BOR:    ctl_c.val = a_s1 | b_s1;
			OP_BXOR:   ctl_c.val = a_s1 ^ b_s1;
			OP_SHL:    ctl_c.val = big_s1 ? '0 : (a_s1 << b_s1[SHIFT_BITS-1:0]);
			OP_SHR:    ctl_c.val = big_s1 ? '0 : (a_s1 >> b_s1[SHIFT_BITS-1:0]);
			OP_WIDTH:  ctl_c.val = b_s1;
			OP_SWIDTH: ctl_c.val = sb_s1;
			OP_ADD:    ctl_c.val = a_s1 + b_s1;
			OP_SUB:    ctl_c.val = a_s1 - b_s1;
			OP_LT:     ctl_c.val = DATA_BITS'(a_s1 < b_s1);
			OP_GT:     ctl_c.val = DATA_BITS'(a_s1 > b_s1);
			OP_LE:     ctl_c.val = DATA_BITS'(a_s1 <= b_s1);
			OP_GE:     ctl_c.val = DATA_BITS'(a_s1 >= b_s1);
			OP_SLT:    ctl_c.val = DATA_BITS'($signed(sa_s1) < $signed(sb_s1));
			OP_SGT:    ctl_c.val = DATA_BITS'($signed(sb_s1) < $signed(sa_s1));
			OP_SLE:    ctl_c.val = DATA_BITS'(!($signed(sb_s1) < $signed(sa_s1)));
			OP_SGE:    ctl_c.val = DATA_BITS'(!($signed(sa_s1) < $signed(sb_s1)));
			OP_EQ:     ctl_c.val = DATA_BITS'(a_s1 == b_s1);
			default:   ctl_c.val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl_c;
			pll_s2 <= DATA_BITS'(a_s1[HALF-1:0] * b_s1[HALF-1:0]);
			plh_s2 <= DATA_BITS'(a_s1[HALF-1:0] * b_s1[DATA_BITS-1:HALF]);
			phl_s2 <= DATA_BITS'(a_s1[DATA_BITS-1:HALF] * b_s1[HALF-1:0]);
			dvd_s2 <= dvd_c;
			dsr_s2 <= dsr_c;
		end
	end

	// ---------------- divider stages: one quotient bit each
	logic                 valid_sd [DATA_BITS];
	ctl_t                 ctl_sd   [DATA_BITS];
	logic [DATA_BITS-1:0] rem_sd   [DATA_BITS];
	logic [DATA_BITS-1:0] quo_sd   [DATA_BITS];
	logic [DATA_BITS-1:0] dsr_sd   [DATA_BITS];

	for (genvar i = 0; i < DATA_BITS; i++) begin : g_div
		logic                 vin;
		ctl_t                 cin;
		logic [DATA_BITS-1:0] rin, qin, din;
		logic [DATA_BITS:0]   sh, diff;

		if (i == 0) begin : g_first
			always_comb begin
				vin = valid_s2;
				cin = ctl_s2;
				// fold the partial products into the product
				if (ctl_s2.op == OP_MUL)
					cin.val = pll_s2 + ((plh_s2 + phl_s2) << HALF);
				rin = '0;
				qin = dvd_s2;
				din = dsr_s2;
			end
		end else begin : g_next
			always_comb begin
				vin = valid_sd[i-1];
				cin = ctl_sd[i-1];
				rin = rem_sd[i-1];
				qin = quo_sd[i-1];
				din = dsr_sd[i-1];
			end
		end

		assign sh   = {rin, qin[DATA_BITS-1]};
		assign diff = sh - {1'b0, din};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_sd[i] <= 1'b0;
			else if (adv)
				valid_sd[i] <= vin;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_sd[i] <= cin;
				dsr_sd[i] <= din;
				if (!diff[DATA_BITS]) begin
					rem_sd[i] <= diff[DATA_BITS-1:0];
					quo_sd[i] <= {qin[DATA_BITS-2:0], 1'b1};
				end else begin
					rem_sd[i] <= sh[DATA_BITS-1:0];
					quo_sd[i] <= {qin[DATA_BITS-2:0], 1'b0};
				end
			end
		end
	end

	// ---------------- output stage: sign fix, select, mask
	ctl_t                 ctl_l;
	logic [DATA_BITS-1:0] quo_l, val_c;

	always_comb begin
		ctl_l = ctl_sd[DATA_BITS-1];
		quo_l = ctl_l.neg ? -quo_sd[DATA_BITS-1] : quo_sd[DATA_BITS-1];
		if ((ctl_l.op == OP_DIV) || (ctl_l.op == OP_SDIV))
			val_c = ctl_l.dz ? '0 : quo_l;
		else
			val_c = ctl_l.val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= valid_sd[DATA_BITS-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_rsp.result_value   <= val_c & width_mask(ctl_l.wid);
			out_rsp.result_width   <= ctl_l.wid;
			out_rsp.divide_by_zero <= ctl_l.dz;
		end
	end

endmodule

// ----- rtl/wtalu_chk.sv -----
// Port-level checks for the width-tagged ALU, bound to the top level.
// Depends on wtalu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wtalu_chk
	import wtalu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input req_t in_req,
	input logic out_valid,
	input logic out_ready,
	input rsp_t out_rsp
);

	`CHK_IMPLY(a_rsp_hold, out_valid && !out_ready, ##1 (out_valid && $stable(out_rsp)))
	`CHK_ASSERT(a_ready_flow, in_ready == (!out_valid || out_ready))
	`CHK_IMPLY(a_width_sat, out_valid, out_rsp.result_width <= WMAX)
	`CHK_IMPLY(a_masked, out_valid, (out_rsp.result_value & ~width_mask(out_rsp.result_width)) == '0)
	`CHK_IMPLY(a_dz_zero, out_valid && out_rsp.divide_by_zero, out_rsp.result_value == '0)

endmodule

bind width_tagged_integer_alu wtalu_chk u_wtalu_chk (.*);

// ----- dv/wtalu_checker.sv -----
// Checker for the width-tagged integer ALU: predicts each response from the
// request and compares field by field. Depends on wtalu_pkg.
module wtalu_checker
	import wtalu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  req_t in_req,
	input  logic out_valid,
	input  logic out_ready,
	input  rsp_t out_rsp,
	output int   fail_count,
	output int   pending
);

	rsp_t alu_expected[$];

	function automatic logic [63:0] wmask(input logic [6:0] w);
		if (w >= 7'd64)
			return '1;
		return (64'd1 << w) - 64'd1;
	endfunction

	function automatic logic [6:0] wsat(input logic [63:0] w);
		return (w > 64'd64) ? 7'd64 : w[6:0];
	endfunction

	function automatic logic [63:0] sext(input logic [63:0] v, input logic [6:0] w);
		logic [63:0] m;
		m = wmask(w);
		if (w == 7'd0)
			return '0;
		if (w >= 7'd64)
			return v;
		v = v & m;
		if (v[w - 7'd1])
			v = v | ~m;
		return v;
	endfunction

	function automatic rsp_t alu_predict(input req_t r);
		rsp_t o;
		logic [63:0] a, b, v, sa, sb, ma, mb;
		logic [6:0] aw, bw, w;
		logic dz;
		a = r.lhs_value;
		b = r.rhs_value;
		aw = wsat({57'd0, r.lhs_width});
		bw = wsat({57'd0, r.rhs_width});
		v = '0;
		w = '0;
		dz = 1'b0;
		sa = sext(a, aw);
		sb = sext(b, bw);
		case (r.action)
		OP_NOT: begin v = 64'(b == '0); w = 7'd1; end
		OP_AND: begin v = 64'(a != '0 && b != '0); w = 7'd1; end
		OP_OR: begin v = 64'(a != '0 || b != '0); w = 7'd1; end
		OP_XOR: begin v = 64'((a != '0) != (b != '0)); w = 7'd1; end
		OP_BNOT: begin v = ~b; w = bw; end
		OP_BAND: begin v = a & b; w = (aw < bw) ? aw : bw; end
		OP_BOR: begin v = a | b; w = (aw > bw) ? aw : bw; end
		OP_BXOR: begin v = a ^ b; w = (aw > bw) ? aw : bw; end
		OP_SHL: begin v = (b >= 64'd64) ? '0 : a << b[5:0]; w = aw; end
		OP_SHR: begin v = (b >= 64'd64) ? '0 : a >> b[5:0]; w = aw; end
		OP_WIDTH: begin v = b; w = wsat(a); end
		OP_SWIDTH: begin v = sext(b, bw); w = wsat(a); end
		OP_ADD: begin v = a + b; w = (aw > bw) ? aw : bw; end
		OP_SUB: begin v = a - b; w = (aw > bw) ? aw : bw; end
		OP_MUL: begin v = a * b; w = (aw > bw) ? aw : bw; end
		OP_DIV: begin
			w = aw;
			if (b == '0)
				dz = 1'b1;
			else
				v = a / b;
		end
		OP_SDIV: begin
			w = aw;
			if (sb == '0)
				dz = 1'b1;
			else begin
				ma = sa[63] ? -sa : sa;
				mb = sb[63] ? -sb : sb;
				v = ma / mb;
				if (sa[63] != sb[63])
					v = -v;
			end
		end
		OP_LT: begin v = 64'(a < b); w = 7'd1; end
		OP_GT: begin v = 64'(a > b); w = 7'd1; end
		OP_LE: begin v = 64'(a <= b); w = 7'd1; end
		OP_GE: begin v = 64'(a >= b); w = 7'd1; end
		OP_SLT: begin v = 64'($signed(sa) < $signed(sb)); w = 7'd1; end
		OP_SGT: begin v = 64'($signed(sa) > $signed(sb)); w = 7'd1; end
		OP_SLE: begin v = 64'($signed(sa) <= $signed(sb)); w = 7'd1; end
		OP_SGE: begin v = 64'($signed(sa) >= $signed(sb)); w = 7'd1; end
		OP_EQ: begin v = 64'(a == b); w = 7'd1; end
		default: begin v = '0; w = '0; end
		endcase
		o.result_value = v & wmask(w);
		o.result_width = w;
		o.divide_by_zero = dz;
		return o;
	endfunction

	assign pending = alu_expected.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			fail_count = 0;
			alu_expected.delete();
		end else begin
			if (in_valid && in_ready)
				alu_expected.push_back(alu_predict(in_req));
			if (out_valid && out_ready) begin
				if (alu_expected.size() == 0) begin
					$error("response with no request outstanding: %h", out_rsp);
					fail_count++;
				end else begin
					e = alu_expected.pop_front();
					if (out_rsp.result_value !== e.result_value) begin
						$error("result_value expected %h actual %h",
							e.result_value, out_rsp.result_value);
						fail_count++;
					end
					if (out_rsp.result_width !== e.result_width) begin
						$error("result_width expected %0d actual %0d",
							e.result_width, out_rsp.result_width);
						fail_count++;
					end
					if (out_rsp.divide_by_zero !== e.divide_by_zero) begin
						$error("divide_by_zero expected %0b actual %0b",
							e.divide_by_zero, out_rsp.divide_by_zero);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the width-tagged integer ALU: drives requests, stalls the
// response side, and reports. Depends on wtalu_pkg and wtalu_checker.
module tb_top;
	import wtalu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_req = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_rsp;
	int   fail_count;
	int   pending;
	int   sent = 0;
	bit   long_hold = 1'b0;
	bit   no_idle = 1'b0;

	width_tagged_integer_alu DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp)
	);

	wtalu_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Bias values toward edges and small magnitudes.
	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		2: return 64'h8000_0000_0000_0000 >> $urandom_range(0, 63);
		3: return 64'($urandom_range(0, 70));
		4: return -64'($urandom_range(1, 5));
		default: return rand64();
		endcase
	endfunction

	function automatic logic [6:0] pick_width();
		case ($urandom_range(0, 5))
		0: return 7'd0;
		1: return 7'd64;
		2: return 7'($urandom_range(65, 127));
		default: return 7'($urandom_range(1, 63));
		endcase
	endfunction

	// Offer one request; hold until accepted. Valid drops only for an idle gap.
	task automatic send_req(input req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_req <= r;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_op(input logic [4:0] op, input logic [63:0] a, input logic [6:0] aw,
	                       input logic [63:0] b, input logic [6:0] bw);
		req_t r;
		r.action = op;
		r.lhs_value = a;
		r.lhs_width = aw;
		r.rhs_value = b;
		r.rhs_width = bw;
		send_req(r);
	endtask

	task automatic send_random();
		req_t r;
		r.action = 5'($urandom_range(0, 31));
		if ($urandom_range(0, 9) == 0)
			r.action = 5'($urandom_range(26, 31));
		else if (r.action > 5'd25)
			r.action = 5'($urandom_range(0, 25));
		r.lhs_value = pick_value();
		r.lhs_width = pick_width();
		r.rhs_value = pick_value();
		r.rhs_width = pick_width();
		if (r.action == OP_SHL || r.action == OP_SHR)
			if ($urandom_range(0, 3) != 0)
				r.rhs_value = 64'($urandom_range(0, 70));
		if (r.action == OP_WIDTH || r.action == OP_SWIDTH)
			if ($urandom_range(0, 3) != 0)
				r.lhs_value = 64'($urandom_range(0, 130));
		send_req(r);
	endtask

	// Response side: random stalls, one long hold-off on request.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				long_hold = 1'b0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	initial begin
		int k;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every operation, edges of widths and values.
		for (int op = 0; op <= 25; op++)
			send_op(5'(op), '1, 7'd64, 64'd3, 7'd127);
		send_op(OP_SHL, 64'd1, 7'd64, 64'd64, 7'd8);
		send_op(OP_SHR, '1, 7'd64, 64'd63, 7'd8);
		send_op(OP_DIV, 64'd9, 7'd8, 64'd0, 7'd8);
		send_op(OP_SDIV, 64'h80, 7'd8, 64'h100, 7'd8);
		send_op(OP_SDIV, 64'h8000_0000_0000_0000, 7'd64, '1, 7'd64);
		send_op(OP_SDIV, 64'hF9, 7'd8, 64'd2, 7'd3);
		send_op(OP_SWIDTH, 64'd200, 7'd0, 64'h80, 7'd8);
		send_op(OP_SWIDTH, 64'd16, 7'd0, 64'h5, 7'd0);
		send_op(OP_SLT, 64'hFF, 7'd8, 64'd1, 7'd0);
		send_op(5'd31, '1, 7'd127, '1, 7'd127);
		send_op(OP_BNOT, '0, 7'd0, '0, 7'd0);
		drain();

		// Random, with one burst against a blocked receiver.
		for (k = 0; k < 1350; k++) begin
			if (k == 400) begin
				no_idle = 1'b1;
				long_hold = 1'b1;
			end
			if (k == 700)
				no_idle = 1'b0;
			if (k == 900)
				drain();
			if (k == 1000)
				no_idle = 1'b1;
			if (k == 1100)
				no_idle = 1'b0;
			send_random();
		end
		drain();

		$display("tb_top: %0d requests sent over all %0d operation codes plus unused codes",
			sent, 26);
		$display("tb_top: included back-pressure burst and idle-gap phases");
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
